// ===== hdl/chs_pkg.sv =====
// chs_pkg: shared types and constants for the chained hash set
// request kinds, result status codes and sequencer states
// no dependencies
`default_nettype none

package chs_pkg;

  localparam int KIND_W     = 2;
  localparam int VALUE_W    = 31;
  localparam int STATUS_W   = 2;
  localparam int BUCKET_W   = 3;
  localparam int CHUNK_W    = 8;
  localparam int NUM_CHUNKS = 4;
  localparam int CHUNK_CNT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_LEN,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/chained_hash_set.sv =====
// chained_hash_set: hash set with fixed-depth chains per bucket
// sequencer around a slot ram and a chain length ram
// depends on chs_pkg, chs_ram, chs_mod
//
//   channel | signals                 | direction
//   request | in_valid in_stall kind value   | in
//   result  | out_valid out_stall status bucket | out
//
// one request at a time; insert writes its slot without scanning the chain,
// delete and search visit the slots of the chain until a match or its end
// the bucket remainder comes first, then slots go one per cycle through
// the single read port of the slot ram
// reset clears chain lengths through per-bucket valid bits, no clearing pass
// a result waiting under out_stall holds the sequencer before it returns idle
`default_nettype none

module chained_hash_set #(
  parameter int NUM_BUCKETS = 7,
  parameter int CHAIN_DEPTH = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [chs_pkg::KIND_W-1:0]      kind,
  input  wire logic [chs_pkg::VALUE_W-1:0]     value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [chs_pkg::STATUS_W-1:0]         status,
  output logic [chs_pkg::BUCKET_W-1:0]         bucket
);

  localparam int BKT_W  = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
  localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int SLOTS  = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int ADDR_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

  chs_pkg::state_t   state, state_next;
  chs_pkg::kind_t    kind_q;
  chs_pkg::status_t  res, res_next;
  logic [chs_pkg::VALUE_W-1:0] value_q;
  logic [BKT_W-1:0]  bkt;
  logic [ADDR_W-1:0] base;
  logic [LEN_W-1:0]  n, n_next;
  logic [LEN_W-1:0]  ridx, ridx_next;
  logic [NUM_BUCKETS-1:0] len_vld;

  logic              hash_done;
  logic [BKT_W-1:0]  hash_rem;

  logic              len_we;
  logic [LEN_W-1:0]  len_wdata;
  logic [LEN_W-1:0]  len_rdata;
  logic [LEN_W-1:0]  len_cur;

  logic                        slot_we;
  logic [ADDR_W-1:0]           slot_waddr;
  logic [chs_pkg::VALUE_W-1:0] slot_wdata;
  logic [ADDR_W-1:0]           slot_raddr;
  logic [chs_pkg::VALUE_W-1:0] slot_rdata;

  logic in_xfer;
  logic out_free;
  logic more;
  logic match;

  assign in_stall = (state != chs_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign len_cur  = len_vld[bkt] ? len_rdata : '0;
  assign more     = (ridx + LEN_W'(1)) < n;
  assign match    = (slot_rdata == value_q);

  chs_mod #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .value (value),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  chs_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NUM_BUCKETS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (bkt),
    .wdata (len_wdata),
    .raddr (hash_rem),
    .rdata (len_rdata)
  );

  chs_ram #(
    .WIDTH (chs_pkg::VALUE_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      chs_pkg::S_IDLE: begin
        if (in_valid) state_next = chs_pkg::S_HASH;
      end
      chs_pkg::S_HASH: begin
        if (hash_done) state_next = chs_pkg::S_LEN;
      end
      chs_pkg::S_LEN: begin
        unique case (kind_q)
          chs_pkg::KIND_DELETE,
          chs_pkg::KIND_SEARCH: begin
            state_next = (len_cur == '0) ? chs_pkg::S_DONE : chs_pkg::S_SCAN;
          end
          default: state_next = chs_pkg::S_DONE;
        endcase
      end
      chs_pkg::S_SCAN: begin
        if (match) begin
          state_next = (kind_q == chs_pkg::KIND_DELETE && more) ?
                       chs_pkg::S_SHIFT : chs_pkg::S_DONE;
        end else if (!more) begin
          state_next = chs_pkg::S_DONE;
        end
      end
      chs_pkg::S_SHIFT: begin
        if (!more) state_next = chs_pkg::S_DONE;
      end
      chs_pkg::S_DONE: begin
        if (out_free) state_next = chs_pkg::S_IDLE;
      end
      default: state_next = chs_pkg::S_IDLE;
    endcase
  end

  // memory controls and working values
  always_comb begin
    len_we     = 1'b0;
    len_wdata  = n - LEN_W'(1);
    slot_we    = 1'b0;
    slot_waddr = base + ADDR_W'(ridx) - ADDR_W'(1);
    slot_wdata = slot_rdata;
    slot_raddr = base + ADDR_W'(ridx) + ADDR_W'(1);
    res_next   = res;
    n_next     = n;
    ridx_next  = ridx;
    unique case (state)
      chs_pkg::S_LEN: begin
        n_next     = len_cur;
        ridx_next  = '0;
        slot_raddr = base;
        res_next   = chs_pkg::STATUS_ABSENT;
        unique case (kind_q)
          chs_pkg::KIND_INSERT: begin
            if (len_cur >= LEN_W'(CHAIN_DEPTH)) begin
              res_next = chs_pkg::STATUS_FULL;
            end else begin
              slot_we    = 1'b1;
              slot_waddr = base + ADDR_W'(len_cur);
              slot_wdata = value_q;
              len_we     = 1'b1;
              len_wdata  = len_cur + LEN_W'(1);
              res_next   = chs_pkg::STATUS_OK;
            end
          end
          default: ;
        endcase
      end
      chs_pkg::S_SCAN: begin
        if (match) begin
          res_next = chs_pkg::STATUS_OK;
          if (kind_q == chs_pkg::KIND_DELETE) begin
            if (more) begin
              ridx_next = ridx + LEN_W'(1);
            end else begin
              len_we = 1'b1;
            end
          end
        end else if (more) begin
          ridx_next = ridx + LEN_W'(1);
        end
      end
      chs_pkg::S_SHIFT: begin
        slot_we = 1'b1;
        if (more) begin
          ridx_next = ridx + LEN_W'(1);
        end else begin
          len_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chs_pkg::S_IDLE;
      out_valid <= 1'b0;
      len_vld   <= '0;
    end else begin
      state <= state_next;
      if (len_we) begin
        len_vld[bkt] <= 1'b1;
      end
      if (state == chs_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_q  <= chs_pkg::kind_t'(kind);
      value_q <= value;
    end
    if (state == chs_pkg::S_HASH && hash_done) begin
      bkt  <= hash_rem;
      base <= ADDR_W'(hash_rem * CHAIN_DEPTH);
    end
    res  <= res_next;
    n    <= n_next;
    ridx <= ridx_next;
    if (state == chs_pkg::S_DONE && out_free) begin
      status <= res;
      bucket <= chs_pkg::BUCKET_W'(bkt);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chs_ram.sv =====
// chs_ram: generic single write port, single read port ram
// read data registered, no reset on contents
// no dependencies
`default_nettype none

module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/chs_mod.sv =====
// chs_mod: value modulo bucket count, eight bits per cycle
// restoring remainder over four chunks, most significant first
// depends on chs_pkg
`default_nettype none

module chs_mod #(
  parameter int NUM_BUCKETS = 7
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [chs_pkg::VALUE_W-1:0]            value,
  output logic                                        done,
  output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] rem
);

  localparam int BKT_W = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
  localparam int DIV_W = BKT_W + chs_pkg::CHUNK_W;
  localparam int SH_W  = chs_pkg::CHUNK_W * chs_pkg::NUM_CHUNKS;

  logic                              busy;
  logic [chs_pkg::CHUNK_CNT_W-1:0]   cnt;
  logic [SH_W-1:0]                   sh;
  logic [BKT_W-1:0]                  rem_next;

  always_comb begin
    logic [DIV_W-1:0] x;
    logic [DIV_W-1:0] d;
    x = {rem, sh[SH_W-1 -: chs_pkg::CHUNK_W]};
    for (int j = chs_pkg::CHUNK_W - 1; j >= 0; j--) begin
      d = DIV_W'(NUM_BUCKETS) << j;
      if (x >= d) begin
        x = x - d;
      end
    end
    rem_next = x[BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + chs_pkg::CHUNK_CNT_W'(1);
      if (cnt == chs_pkg::CHUNK_CNT_W'(chs_pkg::NUM_CHUNKS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= SH_W'(value);
      rem <= '0;
    end else if (busy) begin
      sh  <= sh << chs_pkg::CHUNK_W;
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire
